@@ rtl/wwm_pkg.sv @@
`default_nettype none
// ============================================================================
// wwm_pkg - shared types, constants and functions
// Byte classification, case folding and the cell link types used by the
// whole-word matcher and its shift cells.
// ============================================================================
package wwm_pkg;

    localparam int MAX_WORD_DEF = 8;
    localparam int LEN_W        = 4;
    localparam int WORD_W       = 64;
    localparam int WORD_NBYTES  = WORD_W / 8;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WORD_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_BYTES  = 2'd1;

    // One text position as it travels along the chain.
    typedef struct packed {
        logic       valid;
        logic       letter;
        logic [7:0] fold;
    } t_cell_link;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

    typedef struct packed {
        t_cell_link link;
        logic       eq_own;
        logic       eq_next;
    } t_cell_stat;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if ((c >= 8'h61) && (c <= 8'h7A)) begin
            return c - 8'h20;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/wwm_cell.sv @@
`default_nettype none
// ============================================================================
// wwm_cell - one position of the text window
// Holds a case-folded byte with its letter flag and valid bit, passes it to
// the next cell on every shift, and compares it against two word bytes.
// ============================================================================
module wwm_cell
    import wwm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cell_ctrl i_ctrl,
    input  wire t_cell_link i_prev,
    input  wire logic [7:0] i_word_own,
    input  wire logic [7:0] i_word_next,
    output t_cell_stat      o_stat
);

    t_cell_link r_link;
    t_cell_link n_link;

    always_comb begin
        n_link = r_link;
        if (i_ctrl.shift) begin
            n_link = i_prev;
            // The end of a string empties the window for the next one.
            if (i_ctrl.clear) begin
                n_link.valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.valid <= 1'b0;
        end else begin
            r_link.valid <= n_link.valid;
        end
        r_link.letter <= n_link.letter;
        r_link.fold   <= n_link.fold;
    end

    assign o_stat.link    = r_link;
    assign o_stat.eq_own  = (r_link.fold == i_word_own);
    assign o_stat.eq_next = (r_link.fold == i_word_next);

endmodule
`default_nettype wire

@@ rtl/whole_word_case_insensitive_match_top.sv @@
`default_nettype none
// The found result of a string is in the output register in the cycle
//   after its last byte is accepted.
// Throughput: one text byte per cycle while not stalled; the window is a
//   row of shift cells comparing in parallel, so no byte waits on another.
// Reset (synchronous, active low) empties the window, clears the pending
//   result and sets word_length to 1 and word_bytes to 0.
// ============================================================================
// whole_word_case_insensitive_match_top - whole-word word search
// Streams a string byte by byte through a chain of MAX_WORD+1 cells and
// reports, on its last byte, whether the configured word occurs in it as a
// whole word, ignoring ASCII letter case.
// ============================================================================
module whole_word_case_insensitive_match_top
    import wwm_pkg::*;
#(
    parameter int MAX_WORD = MAX_WORD_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Text input channel.
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [7:0]           i_text_byte,
    input  wire logic                 i_is_last,
    // Result channel.
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_found,
    // Configuration write channel.
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]    i_cfg_data
);

    localparam int NCELL = MAX_WORD + 1;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; an unknown index
    // is dropped.
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]  r_word_length;
    logic [WORD_W-1:0] r_word_bytes;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_length <= LEN_W'(1);
            r_word_bytes  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_WORD_LENGTH: r_word_length <= i_cfg_data[LEN_W-1:0];
                CFG_WORD_BYTES:  r_word_bytes  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A length of zero behaves as one, and anything above MAX_WORD is
    // clipped to MAX_WORD.
    logic [LEN_W-1:0] w_eff_len;

    always_comb begin
        if (r_word_length == '0) begin
            w_eff_len = LEN_W'(1);
        end else if (r_word_length > LEN_W'(MAX_WORD)) begin
            w_eff_len = LEN_W'(MAX_WORD);
        end else begin
            w_eff_len = r_word_length;
        end
    end

    // ------------------------------------------------------------------
    // Word alignment. Cell j holds the byte that arrived j transactions
    // ago, so for an occurrence ending at cell 0 it must match word byte
    // (len-1-j). w_aligned[j] is that byte, case folded; positions at or
    // beyond the word length are masked out by the match logic below.
    // ------------------------------------------------------------------
    logic [7:0] w_aligned [NCELL+1];

    always_comb begin
        for (int j = 0; j <= NCELL; j++) begin
            w_aligned[j] = 8'h00;
            for (int k = 0; k < WORD_NBYTES; k++) begin
                if ((k + j + 1) == int'(w_eff_len)) begin
                    w_aligned[j] = fold_case(r_word_bytes[8*k +: 8]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Handshakes. The output register parts the two sides: a new byte is
    // taken whenever the result register is empty or being drained.
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic r_found;
    logic w_in_acc;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;

    // ------------------------------------------------------------------
    // The cell chain. Cell 0 takes the new byte; every other cell takes
    // its neighbor's content on each accepted transaction.
    // ------------------------------------------------------------------
    t_cell_ctrl w_ctrl;
    t_cell_link w_new;
    t_cell_link w_prev [NCELL];
    t_cell_stat w_stat [NCELL];
    logic [NCELL-1:0] w_valid_vec;

    assign w_ctrl.shift = w_in_acc;
    assign w_ctrl.clear = i_is_last;

    assign w_new.valid  = 1'b1;
    assign w_new.letter = is_letter(i_text_byte);
    assign w_new.fold   = fold_case(i_text_byte);

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_prev[g] = w_new;
        end else begin : g_body
            assign w_prev[g] = w_stat[g-1].link;
        end

        wwm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_prev      (w_prev[g]),
            .i_word_own  (w_aligned[g]),
            .i_word_next (w_aligned[g+1]),
            .o_stat      (w_stat[g])
        );

        assign w_valid_vec[g] = w_stat[g].link.valid;
    end

    // ------------------------------------------------------------------
    // Match decision.
    // Ending at the previous byte: cells 0..len-1 match the word, the cell
    // at position len is empty or not a letter, and the incoming byte is
    // not a letter.
    // Ending at the incoming byte (only judged on the last byte): the new
    // byte matches the word's final byte, cells 0..len-2 match word
    // positions len-2 down to 0 through their neighbor compare, and cell len-1,
    // which becomes the preceding byte, is empty or not a letter.
    // ------------------------------------------------------------------
    logic w_prev_body;
    logic w_prev_before;
    logic w_prev_hit;
    logic w_cur_body;
    logic w_cur_before;
    logic w_cur_hit;

    always_comb begin
        w_prev_body   = 1'b1;
        w_prev_before = 1'b1;
        w_cur_body    = (w_new.fold == w_aligned[0]);
        w_cur_before  = 1'b1;
        for (int j = 0; j < NCELL; j++) begin
            if (j < int'(w_eff_len)) begin
                w_prev_body = w_prev_body && w_stat[j].link.valid && w_stat[j].eq_own;
            end
            if (j == int'(w_eff_len)) begin
                w_prev_before = !(w_stat[j].link.valid && w_stat[j].link.letter);
            end
            if ((j + 1) < int'(w_eff_len)) begin
                w_cur_body = w_cur_body && w_stat[j].link.valid && w_stat[j].eq_next;
            end
            if ((j + 1) == int'(w_eff_len)) begin
                w_cur_before = !(w_stat[j].link.valid && w_stat[j].link.letter);
            end
        end
        w_prev_hit = w_prev_body && w_prev_before && !w_new.letter;
        w_cur_hit  = w_cur_body && w_cur_before;
    end

    // ------------------------------------------------------------------
    // Found flag for the string in flight and the result register.
    // ------------------------------------------------------------------
    logic r_found_so_far;
    logic n_found_so_far;
    logic w_result;

    assign w_result = r_found_so_far || w_prev_hit || w_cur_hit;

    always_comb begin
        n_found_so_far = r_found_so_far;
        if (w_in_acc) begin
            if (i_is_last) begin
                n_found_so_far = 1'b0;
            end else begin
                n_found_so_far = r_found_so_far || w_prev_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found_so_far <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_found_so_far <= n_found_so_far;
            if (w_in_acc && i_is_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_in_acc && i_is_last) begin
            r_found <= w_result;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_last_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_is_last) |=> o_out_valid)
        else $error("last byte accepted but no result presented");

    a_mid_no_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_is_last) |=> !o_out_valid)
        else $error("result presented for a byte that does not end a string");

    a_window_cleared : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_is_last) |=> (w_valid_vec == '0) && !r_found_so_far)
        else $error("string state not cleared after its last byte");

    a_valid_thermo : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid_vec + NCELL'(1)) & w_valid_vec) == '0)
        else $error("cell valid bits are not a contiguous run from cell 0");

endmodule
`default_nettype wire

@@ dv/whole_word_case_insensitive_match_top_tb.sv @@
// ============================================================================
// whole_word_case_insensitive_match_top_tb - self-checking testbench
// Streams strings through the whole-word matcher. A short table of directed
// strings and register writes runs first, then random phases follow. Each
// phase picks a word and length, then sends strings built mostly from that
// word, separators and letter runs. A local copy of the search window
// predicts the found flag of every string, and each flag that comes out is
// checked against it or a typed flag. Both channels idle and stall at random.
// ============================================================================
module whole_word_case_insensitive_match_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wwm_pkg::*;

    localparam int WIN          = MAX_WORD_DEF + 1;
    localparam int RANDOM_BYTES = 800;
    localparam int QUIET_LIMIT  = 1000;

    // Register indexes that the block has no register behind.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 2'd3;

    typedef enum logic [2:0] {
        TOK_WORD,
        TOK_SEP,
        TOK_LETTERS,
        TOK_BROKEN,
        TOK_NOISE
    } t_token;

    // One row of the directed table: either a register write or one text byte.
    // A byte that ends a string may carry a found flag typed in by hand.
    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [WORD_W-1:0]    data;
        logic [7:0]           text;
        logic                 last;
        logic                 typed;
        logic                 want;
    } t_dir_row;

    typedef struct packed {
        logic typed;
        logic want;
    } t_pinned;

    // Clock, reset and every input of the block start at known values.
    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [7:0]           i_text_byte = '0;
    logic                 i_is_last   = 1'b0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0]    i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_found;
    logic                 o_cfg_ready;

    whole_word_case_insensitive_match_top #(
        .MAX_WORD(MAX_WORD_DEF)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_text_byte(i_text_byte),
        .i_is_last  (i_is_last),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_found    (o_found),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------------
    // Predictor state: the newest bytes of the current string (newest at
    // index zero), how many of them are valid, whether a whole-word hit has
    // been confirmed, and this side's copy of the two registers.
    // ------------------------------------------------------------------------
    logic [7:0]        win_bytes [WIN];
    int                win_fill;
    logic              found_latch;
    logic [LEN_W-1:0]  len_reg;
    logic [WORD_W-1:0] word_reg;

    // Found flags still to come out, oldest first.
    logic     found_q [$];
    // Hand-typed flags of the directed strings, one per string end.
    t_pinned  pin_q [$];
    t_dir_row dir_rows [$];

    int   mismatches = 0;
    int   bytes_sent = 0;
    int   quiet      = 0;
    int   stall_hold = 0;
    logic calm       = 1'b0;

    function automatic logic is_alpha(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        return (lc >= 8'h61) && (lc <= 8'h7A);
    endfunction

    function automatic logic [7:0] upper_of(input logic [7:0] c);
        return is_alpha(c) ? (c & 8'hDF) : c;
    endfunction

    // Length zero acts as one, and anything above MAX_WORD_DEF acts as the
    // longest word the block holds.
    function automatic int word_span(input logic [LEN_W-1:0] len);
        if (len == 0) return 1;
        if (len > MAX_WORD_DEF) return MAX_WORD_DEF;
        return int'(len);
    endfunction

    // True when the word ends on the newest byte with non-letters (or the
    // string edge) on both sides. The byte after it is given when known.
    function automatic logic word_ends_here(input logic has_next, input logic [7:0] nxt);
        int span;
        span = word_span(len_reg);
        if (win_fill < span) return 1'b0;
        for (int k = 0; k < span; k++) begin
            if (upper_of(win_bytes[span-1-k]) != upper_of(word_reg[8*k +: 8])) return 1'b0;
        end
        if ((win_fill > span) && is_alpha(win_bytes[span])) return 1'b0;
        if (has_next && is_alpha(nxt)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < WIN; i++) win_bytes[i] = '0;
        win_fill    = 0;
        found_latch = 1'b0;
    endfunction

    // Advances the window by one byte. Returns 1 when the byte ends its
    // string, with the string's found flag in found_now.
    function automatic logic take_byte(input logic [7:0] b, input logic last,
                                       output logic found_now);
        found_now = 1'b0;
        // A hit ending on the previous byte is only settled now that the
        // byte after it is known.
        if (word_ends_here(1'b1, b)) found_latch = 1'b1;
        for (int i = WIN - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
        win_bytes[0] = b;
        if (win_fill < WIN) win_fill++;
        if (!last) return 1'b0;
        if (word_ends_here(1'b0, 8'h00)) found_latch = 1'b1;
        found_now = found_latch;
        clear_window();
        return 1'b1;
    endfunction

    task automatic note_fail(input string what);
        mismatches++;
        if (mismatches <= 10) $display("mismatch at %0t: %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, before the block's
    // own registers move. Results are checked before the byte of the same
    // edge is predicted; a result can never belong to a byte accepted at
    // the same edge, since the block registers it first.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic    got;
        logic    now_found;
        logic    want;
        t_pinned pin;
        if (!i_rst_n) begin
            clear_window();
            len_reg  = LEN_W'(1);
            word_reg = '0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (found_q.size() == 0) begin
                    note_fail($sformatf("found=%0b came out with no string pending",
                                        o_found));
                end else begin
                    want = found_q.pop_front();
                    if (o_found !== want) begin
                        note_fail($sformatf("found expected %0b, actual %0b", want, o_found));
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WORD_LENGTH: len_reg = i_cfg_data[LEN_W-1:0];
                    CFG_WORD_BYTES:  word_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                got = take_byte(i_text_byte, i_is_last, now_found);
                if (got) begin
                    if (pin_q.size() != 0) begin
                        pin = pin_q.pop_front();
                        if (pin.typed) now_found = pin.want;
                    end
                    found_q.insert(found_q.size(), now_found);
                end
            end
        end
    end

    // Result-side stall: short random bursts, now and then a long hold, and
    // none at all while a calm phase runs.
    always @(posedge i_clk) begin
        int r;
        if (calm) begin
            i_out_stall <= 1'b0;
            stall_hold  <= 0;
        end else if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            r = $urandom_range(0, 9);
            i_out_stall <= (r < 3);
            stall_hold  <= (r == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
        end
    end

    // Watchdog: any transaction on any channel resets the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. Each task is entered right after a rising edge.
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Valid is only lowered when a gap is taken, so back-to-back bytes keep
    // it high and just change the payload.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_text_byte <= b;
        i_is_last   <= last;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stops the text stream and waits until every pending flag is out.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (found_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        t_dir_row r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic add_raw(input logic [7:0] b, input logic last, input logic typed,
                           input logic want);
        t_dir_row r;
        r       = '0;
        r.text  = b;
        r.last  = last;
        r.typed = typed;
        r.want  = want;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic add_text(input string s, input logic typed, input logic want);
        for (int i = 0; i < s.len(); i++) add_raw(s[i], i == s.len() - 1, typed, want);
    endtask

    function automatic logic [7:0] any_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? 8'h41 : 8'h61;
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] sep_byte();
        case ($urandom_range(0, 4))
            0:       return 8'h20;
            1:       return 8'h2E;
            2:       return 8'h00;
            3:       return 8'h30 + 8'($urandom_range(0, 9));
            default: return 8'h80 + 8'($urandom_range(0, 127));
        endcase
    endfunction

    // Word bytes are mostly letters, so case folding gets a real workout.
    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] w;
        int                r;
        for (int k = 0; k < WORD_NBYTES; k++) begin
            r = $urandom_range(0, 19);
            if (r < 14)      w[8*k +: 8] = any_letter();
            else if (r < 17) w[8*k +: 8] = sep_byte();
            else             w[8*k +: 8] = 8'($urandom_range(0, 255));
        end
        return w;
    endfunction

    // Builds one string out of tokens around the current word and sends it.
    // Most tokens are the word itself (in random case) or separators, so
    // whole-word hits, letter-bounded near misses and broken copies all
    // turn up often.
    task automatic send_string(input logic [WORD_W-1:0] word, input int span);
        logic [7:0] text_q [$];
        t_token     kind;
        logic [7:0] b;
        int         r;
        int         spoil;
        repeat ($urandom_range(1, 6)) begin
            r = $urandom_range(0, 19);
            kind = (r < 8)  ? TOK_WORD :
                   (r < 13) ? TOK_SEP :
                   (r < 16) ? TOK_LETTERS :
                   (r < 18) ? TOK_BROKEN : TOK_NOISE;
            case (kind)
                TOK_WORD, TOK_BROKEN: begin
                    spoil = (kind == TOK_BROKEN) ? $urandom_range(0, span - 1) : -1;
                    for (int k = 0; k < span; k++) begin
                        b = word[8*k +: 8];
                        if (is_alpha(b) && ($urandom_range(0, 1) == 1)) b = b ^ 8'h20;
                        if (k == spoil) b = 8'($urandom_range(0, 255));
                        text_q.insert(text_q.size(), b);
                    end
                end
                TOK_SEP: text_q.insert(text_q.size(), sep_byte());
                TOK_LETTERS: begin
                    repeat ($urandom_range(1, 3)) text_q.insert(text_q.size(), any_letter());
                end
                default: text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
            endcase
        end
        for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic [LEN_W-1:0]  cur_len;
        logic [WORD_W-1:0] cur_word;
        int                phase;
        int                phase_end;
        int                random_start;

        // Directed table. After reset the word is a single zero byte.
        add_raw(8'h00, 1'b1, 1'b1, 1'b1);
        add_raw(8'hFF, 1'b1, 1'b1, 1'b0);
        // "cat", matched in mixed case, then bounded by letters on each side.
        add_cfg(CFG_WORD_LENGTH, 64'd3);
        add_cfg(CFG_WORD_BYTES, 64'h0000_0000_0074_6163);
        add_text("CaT", 1'b1, 1'b1);
        add_text("xcat", 1'b1, 1'b0);
        add_text("catz", 1'b1, 1'b0);
        add_text("@cat!", 1'b0, 1'b0);
        // Length zero behaves as one. High bytes are not case folded.
        add_cfg(CFG_WORD_LENGTH, 64'd0);
        add_cfg(CFG_WORD_BYTES, 64'h0000_0000_0000_00C1);
        add_raw(8'hE1, 1'b1, 1'b1, 1'b0);
        add_raw(8'hC1, 1'b1, 1'b1, 1'b1);
        // Length 15 saturates to eight. Writes to unmapped indexes must not
        // disturb either register.
        add_cfg(CFG_WORD_LENGTH, 64'd15);
        add_cfg(CFG_WORD_BYTES, 64'h4867_4665_4463_4261);
        add_cfg(CFG_UNMAPPED_A, '1);
        add_cfg(CFG_UNMAPPED_B, 64'd1);
        add_text("AbCdEfGh", 1'b1, 1'b1);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                // Registers only change while nothing is in flight.
                drain_results();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                if (dir_rows[i].last) begin
                    pin_q.insert(pin_q.size(), {dir_rows[i].typed, dir_rows[i].want});
                end
                send_byte(dir_rows[i].text, dir_rows[i].last);
            end
        end

        // Random phases. The first few pin the length and the word to their
        // extremes; every third phase runs with no gaps and no stalls.
        // Draining before each phase also makes the sender wait out every
        // pending result.
        phase        = 0;
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            drain_results();
            calm <= (phase % 3 == 2);
            case (phase)
                0:       cur_len = LEN_W'(0);
                1:       cur_len = LEN_W'(1);
                2:       cur_len = LEN_W'(MAX_WORD_DEF);
                3:       cur_len = LEN_W'(15);
                default: cur_len = LEN_W'($urandom_range(0, 15));
            endcase
            case (phase)
                4:       cur_word = '1;
                5:       cur_word = '0;
                default: cur_word = pick_word();
            endcase
            write_reg(CFG_WORD_LENGTH, WORD_W'(cur_len));
            write_reg(CFG_WORD_BYTES, cur_word);
            if ($urandom_range(0, 2) == 0) begin
                write_reg($urandom_range(0, 1) ? CFG_UNMAPPED_A : CFG_UNMAPPED_B,
                          {$urandom, $urandom});
            end
            phase_end = bytes_sent + $urandom_range(50, 110);
            while (bytes_sent < phase_end) send_string(cur_word, word_span(cur_len));
            phase++;
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (found_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/wwm_pkg.sv
rtl/wwm_cell.sv
rtl/whole_word_case_insensitive_match_top.sv
dv/whole_word_case_insensitive_match_top_tb.sv
